FILE: rtl/sfc_pkg.sv
`timescale 1ns / 1ps
package sfc_pkg;

    localparam int FIFO_DEPTH_DEF = 8;
    localparam int NUM_ROUTES_DEF = 4;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;

    localparam logic [3:0] REG_CONTROL = 4'd0;
    localparam logic [3:0] REG_SETUP   = 4'd1;
    localparam logic [3:0] REG_STATUS  = 4'd2;
    localparam logic [3:0] REG_PIN     = 4'd3;
    localparam logic [3:0] REG_TXDATA  = 4'd4;
    localparam logic [3:0] REG_RXDATA  = 4'd5;
    localparam logic [3:0] REG_CLKDIV  = 4'd6;
    localparam logic [3:0] REG_COUNT   = 4'd7;
    localparam logic [3:0] REG_IDD     = 4'd8;

    localparam logic       CFG_ROUTE = 1'b0;
    localparam logic       CFG_KINDS = 1'b1;

    localparam logic [1:0] KIND_NULL  = 2'd1;
    localparam logic [1:0] KIND_PANEL = 2'd2;

    localparam int SETUP_DMA_POS = 5;
    localparam int SETUP_IRQ_POS = 8;

    localparam logic [7:0] PANEL_CMD  = 8'h95;
    localparam logic [7:0] PANEL_POLL = 8'hff;
    localparam logic [7:0] PANEL_ACK  = 8'h01;
    localparam logic [31:0] PANEL_WORDS = 32'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
    } t_in;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_level;
        logic        unknown_register;
        logic        tx_dropped;
        logic        rx_underrun;
        logic [3:0]  overrun_count;
    } t_out;

endpackage

FILE: rtl/sfc_front.sv
`timescale 1ns / 1ps
// Input skid queue: two entries, so the engine can stall without a bubble upstream.
module sfc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  sfc_pkg::t_in  i_item,
    output logic          o_valid,
    input  logic          i_take,
    output sfc_pkg::t_in  o_item
);
    sfc_pkg::t_in r_q0, r_q1, n_q0, n_q1;
    logic [1:0]   r_cnt, n_cnt;
    logic         w_push;

    assign o_stall = (r_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q0;

    always_comb begin
        n_q0  = r_q0;
        n_q1  = r_q1;
        n_cnt = r_cnt;
        if (i_take && o_valid) begin
            n_q0  = r_q1;
            n_cnt = n_cnt - 2'd1;
        end
        if (w_push) begin
            if (n_cnt == 2'd0) n_q0 = i_item;
            else n_q1 = i_item;
            n_cnt = n_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> o_stall) else $error("full queue not stalling");
    a_no_take_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |=> r_cnt <= 2'd1) else $error("count jumped from empty");
endmodule

FILE: rtl/sfc_engine.sv
`timescale 1ns / 1ps
// Register file, FIFOs and byte shifter. One byte shifts per cycle.
module sfc_engine #(
    parameter int FIFO_DEPTH = sfc_pkg::FIFO_DEPTH_DEF,
    parameter int NUM_ROUTES = sfc_pkg::NUM_ROUTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [7:0]    i_cfg_data,
    input  logic          i_valid,
    output logic          o_take,
    input  sfc_pkg::t_in  i_item,
    output logic          o_valid,
    input  logic          i_stall,
    output sfc_pkg::t_out o_item
);
    localparam int LW = $clog2(FIFO_DEPTH + 1);
    localparam int AW = $clog2(FIFO_DEPTH);
    localparam logic [LW-1:0] DEPTH_L = LW'(FIFO_DEPTH);

    logic [1:0]  r_route;
    logic [7:0]  r_kinds;
    logic [31:0] r_ctrl, r_setup, r_pin, r_clkdiv, r_count, r_left, r_idd;
    logic [3:0]  r_evt;
    logic        r_pend;
    logic [7:0]  r_txf [FIFO_DEPTH];
    logic [7:0]  r_rxf [FIFO_DEPTH];
    logic [LW-1:0] r_txl, r_rxl;
    logic        r_busy;
    logic [3:0]  r_lost;
    logic        r_ovalid;
    sfc_pkg::t_out r_out;
    // r_fin marks an item whose result has not yet been published.
    logic        r_fin;

    logic [1:0] w_kind;
    logic       w_dma, w_route_ok, w_can_shift, w_out_free, w_start;
    logic [7:0] w_sent, w_got;
    logic       w_pset, w_pclr;

    assign w_out_free = !r_ovalid || !i_stall;
    assign o_take     = i_valid && !r_busy && !r_fin && w_out_free;
    assign w_start    = o_take;
    assign o_valid    = r_ovalid;
    assign o_item     = r_out;

    assign w_kind     = r_kinds[{r_route, 1'b0} +: 2];
    assign w_route_ok = (32'(r_route) < NUM_ROUTES)
                        && (w_kind == sfc_pkg::KIND_NULL || w_kind == sfc_pkg::KIND_PANEL);
    assign w_dma      = r_setup[sfc_pkg::SETUP_DMA_POS];
    assign w_can_shift = w_route_ok && (r_txl != '0) && (w_dma || r_rxl < DEPTH_L);
    assign w_sent     = r_txf[0];

    always_comb begin
        w_got  = 8'h00;
        w_pset = 1'b0;
        w_pclr = 1'b0;
        if (w_kind == sfc_pkg::KIND_PANEL) begin
            if (r_count == sfc_pkg::PANEL_WORDS && r_left == sfc_pkg::PANEL_WORDS
                && r_rxl == '0 && w_sent == sfc_pkg::PANEL_CMD) begin
                w_pset = 1'b1;
            end else if (r_pend && r_count == sfc_pkg::PANEL_WORDS && r_left == 32'd1) begin
                w_pclr = 1'b1;
                if (w_sent == sfc_pkg::PANEL_POLL) w_got = sfc_pkg::PANEL_ACK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_route <= '0; r_kinds <= '0;
            r_ctrl <= '0; r_setup <= '0; r_pin <= '0; r_clkdiv <= '0;
            r_count <= '0; r_left <= '0; r_idd <= '0;
            r_evt <= '0; r_pend <= 1'b0;
            r_txl <= '0; r_rxl <= '0;
            r_busy <= 1'b0; r_lost <= '0; r_ovalid <= 1'b0;
            for (int k = 0; k < FIFO_DEPTH; k++) begin
                r_txf[k] <= 8'h00;
                r_rxf[k] <= 8'h00;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == sfc_pkg::CFG_ROUTE) r_route <= i_cfg_data[1:0];
                else r_kinds <= i_cfg_data;
            end
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;

            if (w_start) begin
                r_out.read_data        <= '0;
                r_out.unknown_register <= 1'b0;
                r_out.tx_dropped       <= 1'b0;
                r_out.rx_underrun      <= 1'b0;
                r_lost <= '0;
                r_busy <= 1'b1;
                if (i_item.action == sfc_pkg::ACT_READ) begin
                    case (i_item.reg_index)
                        sfc_pkg::REG_CONTROL: r_out.read_data <= r_ctrl;
                        sfc_pkg::REG_SETUP:   r_out.read_data <= r_setup;
                        sfc_pkg::REG_STATUS:  r_out.read_data <= 32'(r_evt)
                            | (32'(r_txl) << 4) | (32'(r_rxl) << 8);
                        sfc_pkg::REG_PIN:     r_out.read_data <= r_pin;
                        sfc_pkg::REG_TXDATA:  r_out.read_data <= '0;
                        sfc_pkg::REG_RXDATA: begin
                            if (r_rxl == '0) begin
                                r_out.rx_underrun <= 1'b1;
                                r_busy <= 1'b0;
                            end else begin
                                r_out.read_data <= 32'(r_rxf[0]);
                                for (int k = 0; k < FIFO_DEPTH - 1; k++) r_rxf[k] <= r_rxf[k+1];
                                r_rxf[FIFO_DEPTH-1] <= 8'h00;
                                r_rxl <= r_rxl - 1'b1;
                            end
                        end
                        sfc_pkg::REG_CLKDIV:  r_out.read_data <= r_clkdiv;
                        sfc_pkg::REG_COUNT:   r_out.read_data <= r_count;
                        sfc_pkg::REG_IDD:     r_out.read_data <= r_idd;
                        default: begin
                            r_out.unknown_register <= 1'b1;
                            r_busy <= 1'b0;
                        end
                    endcase
                    if (!(i_item.reg_index == sfc_pkg::REG_RXDATA)) r_busy <= 1'b0;
                end else if (i_item.action == sfc_pkg::ACT_WRITE) begin
                    r_busy <= 1'b0;
                    case (i_item.reg_index)
                        sfc_pkg::REG_CONTROL: r_ctrl <= i_item.write_data;
                        sfc_pkg::REG_SETUP:   r_setup <= i_item.write_data;
                        sfc_pkg::REG_STATUS:  r_evt <= r_evt & ~i_item.write_data[3:0];
                        sfc_pkg::REG_PIN:     r_pin <= i_item.write_data;
                        sfc_pkg::REG_TXDATA: begin
                            if (r_txl >= DEPTH_L) begin
                                r_out.tx_dropped <= 1'b1;
                            end else begin
                                r_txf[r_txl[AW-1:0]] <= i_item.write_data[7:0];
                                r_txl <= r_txl + 1'b1;
                                r_busy <= 1'b1;
                            end
                        end
                        sfc_pkg::REG_RXDATA: ;
                        sfc_pkg::REG_CLKDIV:  r_clkdiv <= i_item.write_data;
                        sfc_pkg::REG_COUNT: begin
                            r_count <= i_item.write_data;
                            r_left  <= i_item.write_data;
                            r_rxl   <= '0;
                            r_pend  <= 1'b0;
                        end
                        sfc_pkg::REG_IDD:     r_idd <= i_item.write_data;
                        default:              r_out.unknown_register <= 1'b1;
                    endcase
                end
            end else if (r_busy) begin
                if (w_can_shift) begin
                    for (int k = 0; k < FIFO_DEPTH - 1; k++) r_txf[k] <= r_txf[k+1];
                    r_txf[FIFO_DEPTH-1] <= 8'h00;
                    r_txl <= r_txl - 1'b1;
                    if (w_dma) r_lost <= r_lost + 4'd1;
                    else begin
                        r_rxf[r_rxl[AW-1:0]] <= w_got;
                        r_rxl <= r_rxl + 1'b1;
                    end
                    if (r_left != '0) r_left <= r_left - 32'd1;
                    r_evt <= 4'hf;
                    if (w_pset) r_pend <= 1'b1;
                    else if (w_pclr) r_pend <= 1'b0;
                end else begin
                    r_busy <= 1'b0;
                end
            end
            // Finish: publish result once shifting and register updates settle.
            if (!w_start && !r_busy && r_fin) begin
                r_ovalid <= 1'b1;
                r_out.overrun_count <= r_lost;
                r_out.irq_level <= r_setup[sfc_pkg::SETUP_IRQ_POS] && (r_evt != '0)
                                   && (r_rxl != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fin <= 1'b0;
        else if (w_start) r_fin <= 1'b1;
        else if (!r_busy) r_fin <= 1'b0;
    end

    a_tx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_txl <= DEPTH_L) else $error("tx level overflow");
    a_rx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rxl <= DEPTH_L) else $error("rx level overflow");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_take) else $error("item taken while shifting");
    a_fin_pub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin && !r_busy && !w_start |=> r_ovalid) else $error("result lost");
endmodule

FILE: rtl/spi_fifo_controller_regs.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake        | Payload
// input   | in        | i_valid/o_stall  | i_in  (action, reg_index, write_data)
// output  | out       | o_valid/i_stall  | o_out (read_data, flags, overrun count)
// config  | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// A transaction passes through the input queue, then through the engine, which
// executes it and then publishes the result. A transmit write that is not dropped,
// or a receive read from a non-empty FIFO, starts the shifter, which moves up to
// FIFO_DEPTH bytes in turn and stops once it finds it can move no more.
// Reset is synchronous and active low; it clears the register file and every FIFO level.
// A two-entry input queue absorbs items while the engine works; the engine takes
// the next item once the result is published and the output register is free.
module spi_fifo_controller_regs #(
    parameter int FIFO_DEPTH = sfc_pkg::FIFO_DEPTH_DEF,
    parameter int NUM_ROUTES = sfc_pkg::NUM_ROUTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  sfc_pkg::t_in  i_in,
    output logic          o_valid,
    input  logic          i_stall,
    output sfc_pkg::t_out o_out,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [0:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data
);
    logic         w_qvalid, w_take;
    sfc_pkg::t_in w_qitem;

    // Configuration is always writable; software must write it only when idle (not enforced here).
    assign o_cfg_ready = 1'b1;

    sfc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_in),
        .o_valid(w_qvalid), .i_take(w_take), .o_item(w_qitem)
    );

    sfc_engine #(.FIFO_DEPTH(FIFO_DEPTH), .NUM_ROUTES(NUM_ROUTES)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_valid && o_cfg_ready), .i_cfg_index(i_cfg_index[0]),
        .i_cfg_data(i_cfg_data),
        .i_valid(w_qvalid), .o_take(w_take), .i_item(w_qitem),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_out)
    );
endmodule
